### hw/rtl/wtt_pkg.sv
// ============================================================================
// wtt_pkg
// Shared types and constants of the wildcard three-tuple lookup table.
// ============================================================================
package wtt_pkg;

    localparam int Entries      = 64;
    localparam int PayloadWidth = 64;
    localparam int SlotBits     = $clog2(Entries);

    typedef enum logic [2:0] {
        MODE_ADD       = 3'd0,
        MODE_MODIFY    = 3'd1,
        MODE_FIND      = 3'd2,
        MODE_DELETE    = 3'd3,
        MODE_FLUSH_ADR = 3'd4,
        MODE_FLUSH_ALL = 3'd5,
        MODE_RSVD6     = 3'd6,
        MODE_RSVD7     = 3'd7
    } t_mode;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EXISTS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic        is_v6;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [15:0] port_num;
        logic [7:0]  proto_num;
        logic        port_given;
        logic        proto_given;
        logic [63:0] payload_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] payload_out;
    } t_out_item;

    // Normalized key and payload broadcast to every cell
    typedef struct packed {
        logic                    v6;
        logic [63:0]             hi;
        logic [63:0]             lo;
        logic [15:0]             port;
        logic [7:0]              proto;
        logic                    pg;
        logic                    rg;
        logic [15:0]             port_raw;
        logic [7:0]              proto_raw;
        logic [PayloadWidth-1:0] pay;
    } t_key;

    // Per-cell match flags
    typedef struct packed {
        logic exact;
        logic find;
        logic addr;
        logic free;
    } t_hit;

    // Write command to one cell
    typedef struct packed {
        logic ins;
        logic upd;
        logic clr;
    } t_wr;

    // Chain signals passed from a cell to its higher neighbor
    typedef struct packed {
        logic                    exact_seen;
        logic                    find_seen;
        logic                    free_seen;
        logic [PayloadWidth-1:0] find_pay;
    } t_chain;

endpackage

### hw/rtl/wtt_cell.sv
// ============================================================================
// wtt_cell
// One table slot: stores an entry, compares it with the key and takes part
// in the lowest-slot priority chain.
// ============================================================================
module wtt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wtt_pkg::t_key      i_key,
    input  logic               i_cmp,
    input  logic               i_commit,
    input  logic [2:0]         i_mode,
    input  logic               i_any_exact,
    input  wtt_pkg::t_chain    i_chain,
    output wtt_pkg::t_chain    o_chain,
    output wtt_pkg::t_hit      o_hit
);

    logic                              r_valid;
    logic                              r_v6;
    logic [63:0]                       r_hi;
    logic [63:0]                       r_lo;
    logic [15:0]                       r_port;
    logic [7:0]                        r_proto;
    logic                              r_pg;
    logic                              r_rg;
    logic [wtt_pkg::PayloadWidth-1:0]  r_pay;
    wtt_pkg::t_hit                     r_hit;
    wtt_pkg::t_hit                     n_hit;
    wtt_pkg::t_wr                      wr;
    logic                              own_exact;
    logic                              own_find;
    logic                              own_free;

    // Compare the stored entry with the key
    always_comb begin
        n_hit.addr  = r_valid && r_v6 == i_key.v6 && r_hi == i_key.hi && r_lo == i_key.lo;
        n_hit.exact = n_hit.addr && r_port == i_key.port && r_proto == i_key.proto
                      && r_pg == i_key.pg && r_rg == i_key.rg;
        n_hit.find  = n_hit.addr && (!r_pg || r_port == i_key.port_raw)
                      && (!r_rg || r_proto == i_key.proto_raw);
        n_hit.free  = !r_valid;
    end

    // Hold match flags for the commit cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
        end else if (i_cmp) begin
            r_hit <= n_hit;
        end
    end

    // Resolve lowest-slot priority along the chain
    always_comb begin
        own_exact = r_hit.exact && !i_chain.exact_seen;
        own_find  = r_hit.find && !i_chain.find_seen;
        own_free  = r_hit.free && !i_chain.free_seen;
        o_chain.exact_seen = i_chain.exact_seen || r_hit.exact;
        o_chain.find_seen  = i_chain.find_seen || r_hit.find;
        o_chain.free_seen  = i_chain.free_seen || r_hit.free;
        o_chain.find_pay   = own_find ? r_pay : i_chain.find_pay;
        o_hit = r_hit;
        wr = '0;
        unique case (i_mode)
            wtt_pkg::MODE_ADD:       wr.ins = !i_any_exact && own_free;
            wtt_pkg::MODE_MODIFY: begin
                wr.ins = !i_any_exact && own_free;
                wr.upd = own_exact;
            end
            wtt_pkg::MODE_DELETE:    wr.clr = own_exact;
            wtt_pkg::MODE_FLUSH_ADR: wr.clr = r_hit.addr;
            wtt_pkg::MODE_FLUSH_ALL: wr.clr = 1'b1;
            default:                 wr = '0;
        endcase
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_commit) begin
            if (wr.ins) begin
                r_valid <= 1'b1;
            end else if (wr.clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Entry contents
    always_ff @(posedge i_clk) begin
        if (i_commit && wr.ins) begin
            r_v6    <= i_key.v6;
            r_hi    <= i_key.hi;
            r_lo    <= i_key.lo;
            r_port  <= i_key.port;
            r_proto <= i_key.proto;
            r_pg    <= i_key.pg;
            r_rg    <= i_key.rg;
        end
        if (i_commit && (wr.ins || wr.upd)) begin
            r_pay <= i_key.pay;
        end
    end

endmodule

### hw/rtl/wildcard_three_tuple_table.sv
// ============================================================================
// wildcard_three_tuple_table
// Bounded lookup table of address, port and protocol entries with wildcards.
// ============================================================================
// Input channel i_in_* carries one command item (add, modify, find, delete,
// flush address, flush all); output channel o_out_* returns one status item
// per command, with the matched payload on a successful find.
// Both channels use valid/stall: an item moves when valid is high and stall
// is low.
// Each item passes through these steps: at acceptance the normalized key and
// mode are registered; the key is compared against every slot cell in
// parallel and the per-cell match flags are registered; then lowest-slot
// priority is resolved along the cell chain and, at the commit edge, the
// table is written, the result is loaded into an output register and input
// stall goes low again, so a new item is accepted only once the last commits.
// The steps are set by the registered per-cell match flags between the
// compare and the priority chain, and by the busy flag clearing at commit.
// Synchronous active-low reset empties the table at once (valid bits clear)
// and drops any item in flight. Input stall stays high from acceptance until
// the item commits; while the receiver stalls, the result holds and the item
// in work waits for the output register, so input stall stays high.
// ============================================================================
module wildcard_three_tuple_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  wtt_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output wtt_pkg::t_out_item    o_out_data
);

    localparam int N = wtt_pkg::Entries;

    logic               r_busy;
    logic [2:0]         r_mode;
    wtt_pkg::t_key      r_key;
    wtt_pkg::t_key      n_key;
    logic               r_cmp;
    logic               r_ovalid;
    wtt_pkg::t_out_item r_odata;
    wtt_pkg::t_out_item n_odata;
    logic               accept;
    logic               commit;
    logic               out_free;
    logic               any_exact;
    wtt_pkg::t_chain    chain [N+1];
    wtt_pkg::t_hit      hits  [N];
    logic [N-1:0]       exact_vec;

    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = r_busy;
    assign accept     = i_in_valid && !r_busy;
    assign commit     = r_busy && !r_cmp && out_free;

    // Normalize the incoming key
    always_comb begin
        n_key.v6        = i_in_data.is_v6;
        n_key.hi        = i_in_data.is_v6 ? i_in_data.ip_high : 64'd0;
        n_key.lo        = i_in_data.is_v6 ? i_in_data.ip_low
                                          : {32'd0, i_in_data.ip_low[31:0]};
        n_key.pg        = i_in_data.port_given;
        n_key.rg        = i_in_data.proto_given;
        n_key.port      = i_in_data.port_given ? i_in_data.port_num : 16'd0;
        n_key.proto     = i_in_data.proto_given ? i_in_data.proto_num : 8'd0;
        n_key.port_raw  = i_in_data.port_num;
        n_key.proto_raw = i_in_data.proto_num;
        n_key.pay       = i_in_data.payload_in[wtt_pkg::PayloadWidth-1:0];
    end

    // Sequence: accept, compare, commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cmp  <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_cmp  <= 1'b1;
        end else if (r_cmp) begin
            r_cmp  <= 1'b0;
        end else if (commit) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key  <= n_key;
            r_mode <= i_in_data.mode;
        end
    end

    // Row of slot cells
    assign chain[0] = '0;
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            wtt_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_key       (r_key),
                .i_cmp       (r_cmp),
                .i_commit    (commit),
                .i_mode      (r_mode),
                .i_any_exact (any_exact),
                .i_chain     (chain[g]),
                .o_chain     (chain[g+1]),
                .o_hit       (hits[g])
            );
            assign exact_vec[g] = hits[g].exact;
        end
    endgenerate

    assign any_exact = |exact_vec;

    // Build the result item
    always_comb begin
        n_odata.payload_out = 64'd0;
        n_odata.status      = wtt_pkg::ST_OK;
        unique case (r_mode)
            wtt_pkg::MODE_ADD: begin
                if (any_exact) begin
                    n_odata.status = wtt_pkg::ST_EXISTS;
                end else if (!chain[N].free_seen) begin
                    n_odata.status = wtt_pkg::ST_FULL;
                end
            end
            wtt_pkg::MODE_MODIFY: begin
                if (!any_exact && !chain[N].free_seen) begin
                    n_odata.status = wtt_pkg::ST_FULL;
                end
            end
            wtt_pkg::MODE_FIND: begin
                if (chain[N].find_seen) begin
                    n_odata.payload_out = 64'(chain[N].find_pay);
                end else begin
                    n_odata.status = wtt_pkg::ST_NOTFOUND;
                end
            end
            wtt_pkg::MODE_DELETE: begin
                if (!any_exact) begin
                    n_odata.status = wtt_pkg::ST_NOTFOUND;
                end
            end
            default: n_odata.status = wtt_pkg::ST_OK;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (commit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_odata <= n_odata;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // Every committed item produces a result item next cycle
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("commit without result");

    // No new item while one is in work
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !accept)
        else $error("accept while busy");

    // Compare always precedes commit
    a_cmp_then_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_cmp && !commit)
        else $error("commit skipped compare");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped under stall");

endmodule
